[rtl/undirected_graph_cycle_detect_defines.svh]
`ifndef UNDIRECTED_GRAPH_CYCLE_DETECT_DEFINES_SVH
`define UNDIRECTED_GRAPH_CYCLE_DETECT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UGCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define UGCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ugcd_pkg.sv]
`timescale 1ns / 1ps

package ugcd_pkg;

    // fixed field widths
    localparam int CMD_W = 2;
    localparam int VTX_W = 6;
    localparam int CNT_W = 7;

    localparam int MAX_VERTICES_DEF = 64;
    localparam logic [CNT_W-1:0] VC_RESET = 7'd64;

    // item commands, code 3 is unused
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD_A,
        S_ADD_WR_A,
        S_ADD_RD_B,
        S_ADD_WR_B,
        S_CHK_INIT,
        S_ROOT,
        S_LOAD,
        S_SCAN,
        S_POP,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic cap;
        logic clear_graph;
        logic add_wr;
        logic add_sel;
        logic chk_init;
        logic root_inc;
        logic root_start;
        logic load_row;
        logic scan_skip;
        logic scan_push;
        logic scan_pop;
        logic pop_load;
        logic res_load;
        logic res_value;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic add_ok;
        logic root_end;
        logic root_visited;
        logic scan_end;
        logic depth_zero;
        logic bit_set;
        logic bit_visited;
        logic is_parent;
        logic out_full;
    } t_dp_sts;

endpackage

[rtl/undirected_graph_cycle_detect.sv]
// Cycle detector for an undirected graph of up to MAX_VERTICES vertices, kept as an
// adjacency bit matrix in a RAM with one valid flag per row. An add-edge item is
// accepted, then, if both endpoints lie in the matrix, reads and writes each endpoint
// row in turn; a clear item completes as it is accepted, and a check item runs a
// depth-first walk over vertices below vertex_count (clamped to MAX_VERTICES) and
// returns one has_cycle result. The walk tests one neighbor bit per cycle while
// scanning a row; its worst-case run time is set by the single-bit neighbor scan and
// the registered row and stack RAM reads on each push and pop. Items are taken one
// at a time; add and clear items may be taken while a check result waits in the
// output register. Only check items give a result, cmd 3 is ignored.
`timescale 1ns / 1ps
`include "undirected_graph_cycle_detect_defines.svh"

module undirected_graph_cycle_detect
    import ugcd_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [VTX_W-1:0] i_vertex_a,
    input  logic [VTX_W-1:0] i_vertex_b,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_has_cycle,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data
);

    t_dp_cmd s_cmd;
    t_dp_sts s_sts;

    ugcd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_stall (o_stall),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd)
    );

    ugcd_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vertex_a  (i_vertex_a),
        .i_vertex_b  (i_vertex_b),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_has_cycle (o_has_cycle),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts)
    );

    // checks on the walk and the result register
    `UGCD_ASSERT_IMP(a_res_no_overwrite, i_clk, i_rst_n, s_cmd.res_load,
        !(o_valid && i_stall), "result loaded over a waiting result")
    `UGCD_ASSERT_IMP(a_push_unvisited, i_clk, i_rst_n, s_cmd.scan_push,
        s_sts.bit_set && !s_sts.bit_visited && !s_sts.scan_end,
        "push of a visited or absent neighbor")
    `UGCD_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, s_cmd.scan_pop,
        !s_sts.depth_zero, "pop from an empty walk stack")
    `UGCD_ASSERT_NXT(a_push_busy, i_clk, i_rst_n, s_cmd.scan_push,
        o_stall && !s_sts.depth_zero, "walk push left the block idle or the stack empty")

endmodule

[rtl/ugcd_ram.sv]
`timescale 1ns / 1ps

module ugcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ugcd_ctrl.sv]
`timescale 1ns / 1ps

module ugcd_ctrl
    import ugcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_stall,
    input  t_dp_sts          i_sts,
    output t_dp_cmd          o_cmd
);

    t_state r_state, n_state;
    logic   r_found, n_found;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_found = r_found;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    unique case (t_cmd'(i_cmd))
                        CMD_ADD:   n_state = S_ADD_RD_A;
                        CMD_CHECK: n_state = S_CHK_INIT;
                        CMD_CLEAR: o_cmd.clear_graph = 1'b1;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD_A: begin
                if (i_sts.add_ok) begin
                    n_state = S_ADD_WR_A;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ADD_WR_A: begin
                o_cmd.add_wr = 1'b1;
                n_state      = S_ADD_RD_B;
            end
            S_ADD_RD_B: begin
                o_cmd.add_sel = 1'b1;
                n_state       = S_ADD_WR_B;
            end
            S_ADD_WR_B: begin
                o_cmd.add_wr  = 1'b1;
                o_cmd.add_sel = 1'b1;
                n_state       = S_IDLE;
            end
            S_CHK_INIT: begin
                o_cmd.chk_init = 1'b1;
                n_state        = S_ROOT;
            end
            S_ROOT: begin
                if (i_sts.root_end) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else if (i_sts.root_visited) begin
                    o_cmd.root_inc = 1'b1;
                end else begin
                    o_cmd.root_start = 1'b1;
                    n_state          = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_row = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    if (i_sts.depth_zero) begin
                        o_cmd.root_inc = 1'b1;
                        n_state        = S_ROOT;
                    end else begin
                        o_cmd.scan_pop = 1'b1;
                        n_state        = S_POP;
                    end
                end else if (!i_sts.bit_set) begin
                    o_cmd.scan_skip = 1'b1;
                end else if (!i_sts.bit_visited) begin
                    o_cmd.scan_push = 1'b1;
                    n_state         = S_LOAD;
                end else if (!i_sts.is_parent) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_skip = 1'b1;
                end
            end
            S_POP: begin
                o_cmd.pop_load = 1'b1;
                n_state        = S_LOAD;
            end
            S_DONE: begin
                if (!i_sts.out_full) begin
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_value = r_found;
                    n_state         = S_IDLE;
                end
            end
        endcase
    end

endmodule

[rtl/ugcd_dp.sv]
`timescale 1ns / 1ps

module ugcd_dp
    import ugcd_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [VTX_W-1:0] i_vertex_a,
    input  logic [VTX_W-1:0] i_vertex_b,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_has_cycle,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int FW    = VW + 1 + VW + NW;
    localparam int CMP_W = (CNT_W > NW) ? CNT_W : NW;

    logic [CNT_W-1:0]        r_vc;
    logic [VTX_W-1:0]        r_a, r_b;
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_row;
    logic [VW-1:0]           r_cur, r_par;
    logic                    r_par_none;
    logic [NW-1:0]           r_next, r_root, r_n;
    logic [VW-1:0]           r_depth;
    logic                    r_out_valid, r_has_cycle;

    logic [VW-1:0]           a_idx, b_idx, row_sel, col_sel, w_idx, root_idx;
    logic [NW-1:0]           next_inc, n_clamp;
    logic [CMP_W-1:0]        cfg_ext;
    logic [MAX_VERTICES-1:0] adj_rdata, adj_row, adj_wdata;
    logic [VW-1:0]           adj_raddr;
    logic [FW-1:0]           stk_rdata, stk_wdata;
    logic [VW-1:0]           stk_vertex, stk_par;
    logic                    stk_par_none;
    logic [NW-1:0]           stk_next;

    // index selection
    assign a_idx    = VW'(r_a);
    assign b_idx    = VW'(r_b);
    assign row_sel  = i_cmd.add_sel ? b_idx : a_idx;
    assign col_sel  = i_cmd.add_sel ? a_idx : b_idx;
    assign w_idx    = r_next[VW-1:0];
    assign root_idx = r_root[VW-1:0];
    assign next_inc = r_next + NW'(1);

    // clamp of the vertex count to the matrix size
    assign cfg_ext = CMP_W'(r_vc);
    assign n_clamp = (cfg_ext > CMP_W'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(cfg_ext);

    // adjacency row update, rows never written read as zero
    assign adj_row   = r_row_vld[row_sel] ? adj_rdata : '0;
    assign adj_wdata = adj_row | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << col_sel);

    // adjacency read address
    always_comb begin
        adj_raddr = row_sel;
        if (i_cmd.root_start) begin
            adj_raddr = root_idx;
        end else if (i_cmd.scan_push) begin
            adj_raddr = w_idx;
        end else if (i_cmd.pop_load) begin
            adj_raddr = stk_vertex;
        end
    end

    ugcd_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_wr),
        .i_waddr (row_sel),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    // walk stack, the top frame lives in registers
    assign stk_wdata = {r_cur, r_par_none, r_par, next_inc};
    assign {stk_vertex, stk_par_none, stk_par, stk_next} = stk_rdata;

    ugcd_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_VERTICES)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.scan_push),
        .i_waddr (r_depth),
        .i_wdata (stk_wdata),
        .i_raddr (r_depth - VW'(1)),
        .o_rdata (stk_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc        <= VC_RESET;
            r_row_vld   <= '0;
            r_visited   <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vc <= i_cfg_data;
            end
            if (i_cmd.clear_graph) begin
                r_row_vld <= '0;
            end else if (i_cmd.add_wr) begin
                r_row_vld[row_sel] <= 1'b1;
            end
            if (i_cmd.chk_init) begin
                r_visited <= '0;
            end else if (i_cmd.root_start) begin
                r_visited[root_idx] <= 1'b1;
            end else if (i_cmd.scan_push) begin
                r_visited[w_idx] <= 1'b1;
            end
            if (i_cmd.root_start) begin
                r_depth <= '0;
            end else if (i_cmd.scan_push) begin
                r_depth <= r_depth + VW'(1);
            end else if (i_cmd.scan_pop) begin
                r_depth <= r_depth - VW'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk registers and payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_a <= i_vertex_a;
            r_b <= i_vertex_b;
        end
        if (i_cmd.chk_init) begin
            r_root <= '0;
            r_n    <= n_clamp;
        end else if (i_cmd.root_inc) begin
            r_root <= r_root + NW'(1);
        end
        if (i_cmd.load_row) begin
            r_row <= r_row_vld[r_cur] ? adj_rdata : '0;
        end
        if (i_cmd.root_start) begin
            r_cur      <= root_idx;
            r_par      <= '0;
            r_par_none <= 1'b1;
            r_next     <= '0;
        end else if (i_cmd.scan_push) begin
            r_cur      <= w_idx;
            r_par      <= r_cur;
            r_par_none <= 1'b0;
            r_next     <= '0;
        end else if (i_cmd.pop_load) begin
            r_cur      <= stk_vertex;
            r_par      <= stk_par;
            r_par_none <= stk_par_none;
            r_next     <= stk_next;
        end else if (i_cmd.scan_skip) begin
            r_next <= next_inc;
        end
        if (i_cmd.res_load) begin
            r_has_cycle <= i_cmd.res_value;
        end
    end

    // status back to the controller
    assign o_sts.add_ok       = (32'(r_a) < MAX_VERTICES) && (32'(r_b) < MAX_VERTICES);
    assign o_sts.root_end     = (r_root >= r_n);
    assign o_sts.root_visited = r_visited[root_idx];
    assign o_sts.scan_end     = (r_next >= r_n);
    assign o_sts.depth_zero   = (r_depth == '0);
    assign o_sts.bit_set      = r_row[w_idx];
    assign o_sts.bit_visited  = r_visited[w_idx];
    assign o_sts.is_parent    = !r_par_none && (w_idx == r_par);
    assign o_sts.out_full     = r_out_valid && i_stall;

    assign o_valid     = r_out_valid;
    assign o_has_cycle = r_has_cycle;

endmodule

[verif/ugcd_checker.sv]
`timescale 1ns / 1ps

module ugcd_checker
    import ugcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [VTX_W-1:0] i_vertex_a,
    input  logic [VTX_W-1:0] i_vertex_b,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic             i_has_cycle,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checks_done,
    output int               o_cycles_found
);

    localparam int MAX_V     = MAX_VERTICES_DEF;
    localparam int NO_PARENT = -1;
    localparam int REPORT_MAX = 10;

    // predicted graph and register copy
    logic [MAX_V-1:0] graph_rows [MAX_V];
    logic [CNT_W-1:0] vertex_limit;

    // expected has_cycle answers, oldest first
    bit cycle_answers [$];

    int mismatches;
    int checks_done;
    int cycles_found;

    // depth-first walk over the checked vertices, explicit stack
    function automatic bit graph_has_cycle();
        int n;
        int root;
        int depth;
        int v;
        int w;
        int frame_vtx [MAX_V];
        int frame_par [MAX_V];
        int frame_nxt [MAX_V];
        logic [MAX_V-1:0] seen;
        bit found;
        n = (int'(vertex_limit) > MAX_V) ? MAX_V : int'(vertex_limit);
        seen = '0;
        found = 1'b0;
        for (root = 0; root < n && !found; root++) begin
            if (!seen[root]) begin
                seen[root] = 1'b1;
                frame_vtx[0] = root;
                frame_par[0] = NO_PARENT;
                frame_nxt[0] = 0;
                depth = 1;
                while (depth > 0 && !found) begin
                    v = frame_vtx[depth-1];
                    w = frame_nxt[depth-1];
                    while (w < n && !graph_rows[v][w])
                        w++;
                    if (w >= n) begin
                        depth--;
                    end else begin
                        frame_nxt[depth-1] = w + 1;
                        if (!seen[w]) begin
                            seen[w] = 1'b1;
                            frame_vtx[depth] = w;
                            frame_par[depth] = v;
                            frame_nxt[depth] = 0;
                            depth++;
                        end else if (w != frame_par[depth-1]) begin
                            found = 1'b1;
                        end
                    end
                end
            end
        end
        return found;
    endfunction

    // one item into the predicted graph
    task automatic apply_item(input logic [CMD_W-1:0] cmd, input logic [VTX_W-1:0] a,
                              input logic [VTX_W-1:0] b);
        bit answer;
        case (cmd)
            CMD_ADD: begin
                if (int'(a) < MAX_V && int'(b) < MAX_V) begin
                    graph_rows[a][b] = 1'b1;
                    graph_rows[b][a] = 1'b1;
                end
            end
            CMD_CHECK: begin
                answer = graph_has_cycle();
                cycle_answers = {cycle_answers, answer};
            end
            CMD_CLEAR: begin
                for (int r = 0; r < MAX_V; r++)
                    graph_rows[r] = '0;
            end
            default: begin
                // unused code leaves everything alone
            end
        endcase
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin
        bit want;
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_V; r++)
                graph_rows[r] = '0;
            vertex_limit = VC_RESET;
            cycle_answers.delete();
            mismatches = 0;
            checks_done = 0;
            cycles_found = 0;
        end else begin
            if (i_cfg_we)
                vertex_limit = i_cfg_data;

            // compare a delivered result with the oldest answer
            if (i_out_valid && !i_out_stall) begin
                if (cycle_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("[%0t] unexpected result: has_cycle %0d with none pending",
                                 $realtime, i_has_cycle);
                end else begin
                    want = cycle_answers.pop_front();
                    checks_done++;
                    if (i_has_cycle)
                        cycles_found++;
                    if (i_has_cycle !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("[%0t] has_cycle wrong: expected %0d, got %0b",
                                     $realtime, want, i_has_cycle);
                    end
                end
            end

            if (i_in_valid && !i_in_stall)
                apply_item(i_cmd, i_vertex_a, i_vertex_b);
        end

        // published after the edge so readers see a settled value
        o_fail_count   <= mismatches;
        o_pending      <= cycle_answers.size();
        o_checks_done  <= checks_done;
        o_cycles_found <= cycles_found;
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb
    import ugcd_pkg::*;
();

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE       = 16;
    localparam int TAIL_CYCLES  = 64;
    localparam int LONG_HOLD    = 400;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic             clk;
    logic             rst_n    = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [CMD_W-1:0] cmd      = '0;
    logic [VTX_W-1:0] vtx_a    = '0;
    logic [VTX_W-1:0] vtx_b    = '0;
    logic             out_valid;
    logic             rx_stall = 1'b0;
    logic             has_cycle;
    logic             cfg_we   = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int checks_done;
    int cycles_found;

    int burst_left    = 0;
    int items_sent    = 0;
    int settings_used = 0;
    int hold_requests = 0;

    undirected_graph_cycle_detect dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_cmd      (cmd),
        .i_vertex_a (vtx_a),
        .i_vertex_b (vtx_b),
        .o_valid    (out_valid),
        .i_stall    (rx_stall),
        .o_has_cycle(has_cycle),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    ugcd_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_vertex_a    (vtx_a),
        .i_vertex_b    (vtx_b),
        .i_out_valid   (out_valid),
        .i_out_stall   (rx_stall),
        .i_has_cycle   (has_cycle),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checks_done (checks_done),
        .o_cycles_found(cycles_found)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run limit
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin : rx_side
        int hold_left;
        int mode_left;
        int mode;
        int holds_served;
        hold_left = 0;
        mode_left = 0;
        mode = 0;
        holds_served = 0;
        forever begin
            @(posedge clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                rx_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0:       rx_stall <= 1'b0;
                    1:       rx_stall <= ($urandom_range(0, 99) < 40);
                    default: rx_stall <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    // offer one item and hold it until taken; valid stays high inside a burst
    task automatic send_item(input logic [CMD_W-1:0] c, input logic [VTX_W-1:0] a,
                             input logic [VTX_W-1:0] b);
        int gap;
        in_valid <= 1'b1;
        cmd      <= c;
        vtx_a    <= a;
        vtx_b    <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end else begin
            burst_left--;
        end
    endtask

    // drop valid and wait for every pending answer plus the add tail
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_vertex_count(input int value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value[CNT_W-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    function automatic logic [VTX_W-1:0] any_vertex();
        return VTX_W'($urandom_range(0, 63));
    endfunction

    // mostly forest growth with random chords, plus repeats, clears and noise
    task automatic run_random_phase(input int vc, input int n_items);
        logic [VTX_W-1:0] order [64];
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic [VTX_W-1:0] last_a;
        logic [VTX_W-1:0] last_b;
        bit has_last;
        int span;
        int placed;
        int done_items;
        int roll;
        int j;
        write_vertex_count(vc);
        span = (vc > 64) ? 64 : vc;
        if (vc == 0)
            span = 8;
        else if (span < 2)
            span = 2;
        for (int i = 0; i < 64; i++)
            order[i] = VTX_W'(i);
        for (int i = span - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            a = order[i];
            order[i] = order[j];
            order[j] = a;
        end
        last_a = '0;
        last_b = '0;
        has_last = 1'b0;
        placed = 1;
        send_item(CMD_CLEAR, any_vertex(), any_vertex());
        done_items = 1;
        while (done_items < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 48 && placed < span) begin
                // new vertex hung on the tree, keeps the graph acyclic
                a = order[placed];
                b = order[$urandom_range(0, placed - 1)];
                placed++;
                if ($urandom_range(0, 1))
                    send_item(CMD_ADD, a, b);
                else
                    send_item(CMD_ADD, b, a);
                last_a = a;
                last_b = b;
                has_last = 1'b1;
                done_items++;
            end else if (roll < 56 && has_last) begin
                // repeated edge, either direction
                if ($urandom_range(0, 1))
                    send_item(CMD_ADD, last_b, last_a);
                else
                    send_item(CMD_ADD, last_a, last_b);
                done_items++;
            end else if (roll < 62) begin
                // chord inside the range, possibly a self-loop
                send_item(CMD_ADD, order[$urandom_range(0, span - 1)],
                          order[$urandom_range(0, span - 1)]);
                done_items++;
            end else if (roll < 68) begin
                send_item(CMD_ADD, any_vertex(), any_vertex());
                done_items++;
            end else if (roll < 72) begin
                send_item(CMD_UNUSED, any_vertex(), any_vertex());
            end else if (roll < 79) begin
                send_item(CMD_CLEAR, any_vertex(), any_vertex());
                placed = 1;
                has_last = 1'b0;
                done_items++;
            end else begin
                send_item(CMD_CHECK, any_vertex(), any_vertex());
                done_items++;
            end
        end
    endtask

    // main sequence
    initial begin : stimulus
        int total_fails;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty graph, path, triangle, clear, self-loop at top vertex
        send_item(CMD_CHECK, 6'd0, 6'd63);
        send_item(CMD_ADD, 6'd0, 6'd1);
        send_item(CMD_ADD, 6'd1, 6'd2);
        send_item(CMD_CHECK, 6'd0, 6'd0);
        send_item(CMD_ADD, 6'd2, 6'd0);
        send_item(CMD_CHECK, 6'd63, 6'd63);
        send_item(CMD_CLEAR, 6'd63, 6'd0);
        send_item(CMD_CHECK, 6'd0, 6'd0);
        send_item(CMD_ADD, 6'd63, 6'd63);
        send_item(CMD_CHECK, 6'd0, 6'd0);
        // repeated edge stays a single edge
        send_item(CMD_CLEAR, 6'd0, 6'd0);
        send_item(CMD_ADD, 6'd5, 6'd6);
        send_item(CMD_ADD, 6'd6, 6'd5);
        send_item(CMD_ADD, 6'd5, 6'd6);
        send_item(CMD_CHECK, 6'd0, 6'd0);
        // unused code is ignored
        send_item(CMD_UNUSED, 6'd63, 6'd0);
        send_item(CMD_CHECK, 6'd0, 6'd0);
        // cycle that leaves the checked range is not seen
        write_vertex_count(4);
        send_item(CMD_ADD, 6'd2, 6'd3);
        send_item(CMD_ADD, 6'd3, 6'd10);
        send_item(CMD_ADD, 6'd10, 6'd2);
        send_item(CMD_CHECK, 6'd0, 6'd0);
        send_item(CMD_ADD, 6'd63, 6'd0);
        send_item(CMD_CHECK, 6'd0, 6'd0);
        // zero vertices walked even with a self-loop present
        write_vertex_count(0);
        send_item(CMD_ADD, 6'd1, 6'd1);
        send_item(CMD_CHECK, 6'd0, 6'd0);

        // random phases over several vertex counts
        run_random_phase(3, 12);
        run_random_phase(127, 10);
        run_random_phase(0, 10);
        run_random_phase(1, 10);
        run_random_phase(12, 14);

        // output held off while checks keep coming, block must back up
        write_vertex_count(6);
        hold_requests <= hold_requests + 1;
        send_item(CMD_CLEAR, 6'd0, 6'd0);
        send_item(CMD_ADD, 6'd0, 6'd1);
        send_item(CMD_CHECK, 6'd0, 6'd0);
        send_item(CMD_ADD, 6'd1, 6'd2);
        send_item(CMD_CHECK, 6'd0, 6'd0);
        send_item(CMD_ADD, 6'd2, 6'd0);
        send_item(CMD_CHECK, 6'd0, 6'd0);
        send_item(CMD_CHECK, 6'd0, 6'd0);
        drain_results();

        run_random_phase(20, 12);
        run_random_phase($urandom_range(2, 16), 12);
        run_random_phase(40, 10);
        run_random_phase(int'(VC_RESET), 10);

        // wait out the tail
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        total_fails = fail_count + pending;

        $display("run covered %0d items across %0d vertex_count settings",
                 items_sent, settings_used + 1);
        $display("%0d checks answered, %0d of them reported a cycle",
                 checks_done, cycles_found);
        if (total_fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/ugcd_pkg.sv
rtl/ugcd_ram.sv
rtl/ugcd_ctrl.sv
rtl/ugcd_dp.sv
rtl/undirected_graph_cycle_detect.sv
verif/ugcd_checker.sv
verif/tb.sv
